// ----- design/ccw_pkg.sv -----
// ----------------------------------------------------------------------------
// ccw_pkg
// Shared widths, limits and the result record of the coin change way counter.
// ----------------------------------------------------------------------------
package ccw_pkg;

    localparam int COIN_W = 10;
    localparam int SUM_W  = 10;
    localparam int WAY_W  = 63;

    localparam logic [WAY_W-1:0] WAY_MAX = {WAY_W{1'b1}};

    typedef struct packed {
        logic [WAY_W-1:0] way_count;
        logic             saturated;
    } t_result;

endpackage

// ----- design/coin_change_way_counter.sv -----
// ----------------------------------------------------------------------------
// coin_change_way_counter
// Counts the ways to form a target sum from unlimited coins of given values.
// ----------------------------------------------------------------------------
// Each slave beat carries one coin value, the target sum and tlast marking
// the final coin of a set. The first coin of a set rebuilds the table of way
// counts from scratch; every usable coin then adds ways[j-coin] into ways[j]
// for ascending j. Zero coins and coins not below TABLE_DEPTH add no ways;
// as a first coin they rebuild the table only. The last coin of a set yields
// one master beat with the count for the target sum and, in tuser, whether
// any entry saturated at 2^63-1. Timing: the sweep walks the table one entry
// per cycle through a single read-modify-write pipeline on a dual read port
// memory. The first coin of a set sweeps the whole table, a later usable coin
// the entries from its own value up, and a skipped coin none. A last coin
// then looks up the target entry and passes it on as the master beat. The
// next beat is taken once the sweep and lookup are done.
// Reset clears the control state only; the table holds no valid data until
// the first coin of a set has rebuilt it. A result waits in the output
// register while the master side stalls; a further result then holds the
// sequencer until the register frees.
// ----------------------------------------------------------------------------
module coin_change_way_counter #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // coin_value [9:0], target_sum [19:10]
    input  logic        s_axis_tlast,   // last_coin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // way_count [62:0]
    output logic        m_axis_tuser    // saturated
);

    import ccw_pkg::*;

    logic    res_valid;
    logic    res_free;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign res_free = !r_out_valid || m_axis_tready;

    ccw_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_coin      (s_axis_tdata[COIN_W-1:0]),
        .i_target    (s_axis_tdata[COIN_W+SUM_W-1:COIN_W]),
        .i_last      (s_axis_tlast),
        .o_res_valid (res_valid),
        .i_res_free  (res_free),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_free) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.way_count};
    assign m_axis_tuser  = r_out.saturated;

endmodule

// ----- design/ccw_ram.sv -----
// ----------------------------------------------------------------------------
// ccw_ram
// Way count table: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ccw_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- design/ccw_core.sv -----
// ----------------------------------------------------------------------------
// ccw_core
// Sequencer and read-modify-write pipeline that sweeps the way count table
// for each usable or first coin and looks up the target entry on the last coin of a set.
// ----------------------------------------------------------------------------
module ccw_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ccw_pkg::COIN_W-1:0]    i_coin,
    input  logic [ccw_pkg::SUM_W-1:0]     i_target,
    input  logic                          i_last,
    output logic                          o_res_valid,
    input  logic                          i_res_free,
    output ccw_pkg::t_result              o_res
);

    import ccw_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_LOOK,
        ST_GET
    } t_state;

    t_state           r_state;
    logic             r_first;
    logic             r_ovf;
    logic             r_last;
    logic             r_clear;
    logic             r_use;
    logic [AW-1:0]    r_coin;
    logic [AW-1:0]    r_j;
    logic [AW-1:0]    r_target;
    logic             r_tgt_ok;

    logic             r_s1_valid;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_has_a;
    logic             r_s1_has_b;
    logic             r_s1_one;
    logic             r_s1_fwd;
    logic [WAY_W-1:0] r_fwd_data;

    logic             coin_ok;
    logic [AW-1:0]    addr_b;
    logic             has_b;
    logic             j_end;
    logic [WAY_W-1:0] rdata_a;
    logic [WAY_W-1:0] rdata_b;
    logic [WAY_W-1:0] term_a;
    logic [WAY_W-1:0] term_b;
    logic [WAY_W:0]   sum;
    logic             sat;
    logic [WAY_W-1:0] wdata;
    logic             re_a;
    logic [AW-1:0]    raddr_a;

    assign coin_ok = (i_coin != '0) && (32'(i_coin) < TABLE_DEPTH);
    assign addr_b  = r_j - r_coin;
    assign has_b   = r_use && (r_j >= r_coin);
    assign j_end   = (r_j == AW'(TABLE_DEPTH - 1));

    assign term_a = r_s1_has_a ? rdata_a : '0;
    assign term_b = r_s1_has_b ? (r_s1_fwd ? r_fwd_data : rdata_b) : '0;
    assign sum    = {1'b0, term_a} + {1'b0, term_b} + {{WAY_W{1'b0}}, r_s1_one};
    assign sat    = sum[WAY_W];
    assign wdata  = sat ? WAY_MAX : sum[WAY_W-1:0];

    assign re_a    = (r_state == ST_RUN) || (r_state == ST_LOOK);
    assign raddr_a = (r_state == ST_LOOK) ? r_target : r_j;

    ccw_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WAY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (r_s1_valid),
        .i_waddr   (r_s1_addr),
        .i_wdata   (wdata),
        .i_re_a    (re_a),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (r_state == ST_RUN),
        .i_raddr_b (addr_b),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_first    <= 1'b1;
            r_ovf      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= (r_state == ST_RUN);
            if (r_s1_valid && sat) begin
                r_ovf <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_last   <= i_last;
                        r_first  <= i_last;
                        r_clear  <= r_first;
                        r_use    <= coin_ok;
                        r_coin   <= AW'(i_coin);
                        r_target <= AW'(i_target);
                        r_tgt_ok <= (32'(i_target) < TABLE_DEPTH);
                        r_j      <= r_first ? '0 : AW'(i_coin);
                        if (r_first) begin
                            r_ovf <= 1'b0;
                        end
                        if (r_first || coin_ok) begin
                            r_state <= ST_RUN;
                        end else if (i_last) begin
                            r_state <= ST_LOOK;
                        end
                    end
                end
                ST_RUN: begin
                    r_s1_addr  <= r_j;
                    r_s1_has_a <= !r_clear;
                    r_s1_has_b <= has_b;
                    r_s1_one   <= r_clear && (r_j == '0);
                    r_s1_fwd   <= has_b && r_s1_valid && (addr_b == r_s1_addr);
                    r_fwd_data <= wdata;
                    r_j        <= r_j + 1'b1;
                    if (j_end) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= r_last ? ST_LOOK : ST_IDLE;
                end
                ST_LOOK: begin
                    r_state <= ST_GET;
                end
                ST_GET: begin
                    if (i_res_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_res_valid     = (r_state == ST_GET);
    assign o_res.way_count = r_tgt_ok ? rdata_a : '0;
    assign o_res.saturated = r_ovf;

    a_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("table write outside a sweep");

    a_fwd_unit_coin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> (r_coin == AW'(1)))
        else $error("forwarding used for a coin other than one");

    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !r_s1_valid)
        else $error("beat accepted while a table write is in flight");

    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && sat) |=> r_ovf)
        else $error("saturation not recorded");

endmodule

// ----- tb/coin_change_way_counter_tb.sv -----
// ----------------------------------------------------------------------------
// coin_change_way_counter_tb
// Self-checking bench for the coin change way counter.
// ----------------------------------------------------------------------------
// Coins are streamed in sets, and each set ends on a tlast beat that asks for
// the way count of a target sum. A scoreboard keeps its own table of way
// counts and rebuilds it coin by coin. It queues the count and the saturation
// flag for each set, and it checks every master beat against the oldest entry
// in that queue. A short directed run covers the following: zero coins, the
// largest coin and target, a target of zero, and a set that saturates. It is
// followed by random sets of mixed length. Some random sets use dense runs of
// small coins so that saturation recurs. The sender works in bursts. The
// receiver stalls in changing patterns, and once it holds off long enough for
// the block to back up.
// ----------------------------------------------------------------------------
module coin_change_way_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccw_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 580;
    localparam int LONG_HOLD    = 12000;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    class t_way_count_scoreboard;
        logic [WAY_W-1:0] sum_ways [TABLE_DEPTH];
        bit               new_set;
        bit               sat_seen;
        t_result          pending [$];
        int               errors;
        int               results;

        function new();
            new_set  = 1'b1;
            sat_seen = 1'b0;
            errors   = 0;
            results  = 0;
        endfunction

        function void note_coin(logic [COIN_W-1:0] coin, logic [SUM_W-1:0] target, bit last);
            logic [WAY_W:0] total;
            t_result        want;
            if (new_set) begin
                foreach (sum_ways[j]) sum_ways[j] = '0;
                sum_ways[0] = 1;
                sat_seen    = 1'b0;
                new_set     = 1'b0;
            end
            if (coin != 0 && int'(coin) < TABLE_DEPTH) begin
                for (int j = int'(coin); j < TABLE_DEPTH; j++) begin
                    total = {1'b0, sum_ways[j]} + {1'b0, sum_ways[j - int'(coin)]};
                    if (total > {1'b0, WAY_MAX}) begin
                        sum_ways[j] = WAY_MAX;
                        sat_seen    = 1'b1;
                    end else begin
                        sum_ways[j] = total[WAY_W-1:0];
                    end
                end
            end
            if (last) begin
                want.way_count = (int'(target) < TABLE_DEPTH) ? sum_ways[target] : '0;
                want.saturated = sat_seen;
                pending.push_back(want);
                new_set = 1'b1;
            end
        endfunction

        function void check_result(logic [WAY_W-1:0] count, logic flag);
            t_result want;
            results++;
            if (pending.size() == 0) begin
                $display("%0t ns: result beat with none expected, actual count %0d flag %0b",
                         $time, count, flag);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (count !== want.way_count) begin
                $display("%0t ns: way_count mismatch, expected %0d, actual %0d",
                         $time, want.way_count, count);
                errors++;
            end
            if (flag !== want.saturated) begin
                $display("%0t ns: saturated mismatch, expected %0b, actual %0b",
                         $time, want.saturated, flag);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // coin_value [9:0], target_sum [19:10]
    logic        s_axis_tlast;   // last_coin
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // way_count [62:0]
    logic        m_axis_tuser;   // saturated

    t_way_count_scoreboard sb = new();
    int                    burst_left = 0;

    coin_change_way_counter #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #(50_000_000);
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[WAY_W-1:0], m_axis_tuser);
        end
        if (s_axis_tvalid && s_axis_tready) begin
            sb.note_coin(s_axis_tdata[COIN_W-1:0], s_axis_tdata[COIN_W+SUM_W-1:COIN_W],
                         s_axis_tlast);
        end
    end

    // The receiver changes its stall pattern every so often, and it holds off
    // once for a long stretch so that results back up into the block.
    initial begin
        int       hold;
        int       mode_left;
        bit       long_done;
        t_rx_mode mode;
        hold          = 0;
        mode_left     = 0;
        long_done     = 1'b0;
        mode          = RX_OPEN;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_done && sb.results >= 12) begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: begin
                        m_axis_tready = 1'b1;
                    end
                    RX_RANDOM: begin
                        m_axis_tready = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_axis_tready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    task automatic offer_coin(input logic [COIN_W-1:0] coin, input logic [SUM_W-1:0] target,
                              input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, target, coin};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        int                sent;
        int                len;
        int                waited;
        logic [COIN_W-1:0] coin;
        logic [SUM_W-1:0]  target;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        offer_coin(0, 0, 1'b1);
        offer_coin(1023, 1023, 1'b1);
        offer_coin(1023, 1022, 1'b1);
        offer_coin(1, 77, 1'b0);
        offer_coin(2, 300, 1'b0);
        offer_coin(0, 5, 1'b0);
        offer_coin(5, 10, 1'b1);
        offer_coin(3, 1, 1'b0);
        offer_coin(0, 9, 1'b1);
        offer_coin(0, 2, 1'b0);
        offer_coin(7, 4, 1'b0);
        offer_coin(4, 511, 1'b1);
        for (int k = 16; k >= 1; k--) begin
            offer_coin(COIN_W'(k), 1023, k == 1);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                len = $urandom_range(14, 20);
                for (int k = len; k >= 1; k--) begin
                    offer_coin(COIN_W'(k), SUM_W'($urandom_range(0, 1023)), k == 1);
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int n = 0; n < len; n++) begin
                    case ($urandom_range(0, 9))
                        0:       coin = '0;
                        1, 2:    coin = COIN_W'($urandom_range(0, 1023));
                        default: coin = COIN_W'($urandom_range(1, 40));
                    endcase
                    target = ($urandom_range(0, 3) == 0) ? SUM_W'($urandom_range(0, 64))
                                                         : SUM_W'($urandom_range(0, 1023));
                    offer_coin(coin, target, n == len - 1);
                end
            end
            sent += len;
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
